// File: hdl/wkdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiegand key door controller package
// Shared widths, codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package wkdc_pkg;

	// Card code length and the bit that selects the key for the upper bits.
	localparam int CODE_BITS  = 26;
	localparam int SELECT_BIT = 14;

	localparam int COUNT_W = $clog2(CODE_BITS + 1);
	localparam int IDX_W   = $clog2(CODE_BITS);
	localparam int TIME_W  = 16;

	// Configuration port.
	localparam int NUM_REGS   = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = CODE_BITS;

	// Stream payload widths.
	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 2;
	localparam int OUT_W     = 2 + 1 + 1 + 1 + COUNT_W;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Reset values of the timing registers, in ticks.
	localparam logic [TIME_W-1:0] UNLOCK_DRIVE_RST = TIME_W'(1000);
	localparam logic [TIME_W-1:0] RELEASE_RST      = TIME_W'(3000);
	localparam logic [TIME_W-1:0] DEBOUNCE_RST     = TIME_W'(100);
	localparam logic [TIME_W-1:0] SETTLE_RST       = TIME_W'(1250);
	localparam logic [TIME_W-1:0] LOCK_DRIVE_RST   = TIME_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_E        = 3'd0,
		REG_KEY_C        = 3'd1,
		REG_UNLOCK_DRIVE = 3'd2,
		REG_RELEASE      = 3'd3,
		REG_DEBOUNCE     = 3'd4,
		REG_SETTLE       = 3'd5,
		REG_LOCK_DRIVE   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_BIT0 = 2'd1,
		KIND_BIT1 = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SERVO_OFF    = 2'd0,
		SERVO_LOCK   = 2'd1,
		SERVO_UNLOCK = 2'd2
	} servo_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_UNLOCK   = 3'd1,
		PH_RELEASE  = 3'd2,
		PH_WATCH    = 3'd3,
		PH_DEBOUNCE = 3'd4,
		PH_SETTLE   = 3'd5,
		PH_LOCK     = 3'd6
	} phase_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] key_e;
		logic [CODE_BITS-1:0] key_c;
		logic [TIME_W-1:0]    unlock_drive;
		logic [TIME_W-1:0]    release_t;
		logic [TIME_W-1:0]    debounce;
		logic [TIME_W-1:0]    settle;
		logic [TIME_W-1:0]    lock_drive;
	} cfg_t;

endpackage

// File: hdl/wiegand_key_door_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiegand key door controller
// Checks 26-bit Wiegand card codes against two keys and runs the door
// unlock / watch / lock sequence from millisecond ticks.
// ----------------------------------------------------------------------------
// A result item passes through the input register, then the result register,
// and waits there longer if the output side stalls.
// Throughput: one item per cycle while the output side keeps up.
// Reset: arst_n clears the receiver and the sequencer to idle and loads the
// register defaults (keys zero, times 1000/3000/100/1250/1000 ticks).
// ----------------------------------------------------------------------------
module wiegand_key_door_controller
	import wkdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // [0] door_low, rest zero
	input  logic [S_TUSER_W-1:0]  s_tuser,  // [1:0] kind
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [1:0] servo_cmd, [2] door_busy, [3] key_rejected, [4] key_accepted,
	// [9:5] bits_received, rest zero
	output logic [M_TDATA_W-1:0]  m_tdata,
	// Configuration writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;

	wkdc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ------------------------------------------------------------------
	// Input register. It refills in the same cycle that its item moves on,
	// so the block takes one item per cycle while the result side keeps up.
	// ------------------------------------------------------------------
	logic  valid_s1;
	kind_t kind_s1;
	logic  door_s1;
	logic  advance;

	assign advance  = valid_s1 & (~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= kind_t'(s_tuser[1:0]);
			door_s1 <= s_tdata[0];
		end
	end

	// ------------------------------------------------------------------
	// Receiver and door sequencer state.
	// ------------------------------------------------------------------
	phase_t             phase_q, phase_d;
	logic [TIME_W-1:0]  timer_q, timer_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               mis_q, mis_d;
	logic               use_e_q, use_e_d;
	logic               acc_d, rej_d;

	logic [TIME_W-1:0]  timer_inc;
	logic [TIME_W-1:0]  timer_lim;
	logic               timer_end;
	logic [COUNT_W-1:0] count_inc;
	logic [IDX_W-1:0]   bit_idx;
	logic               bit_val;
	logic               want_bit;
	logic               mis_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			count_q <= '0;
			mis_q   <= 1'b0;
			use_e_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			count_q <= count_d;
			mis_q   <= mis_d;
			use_e_q <= use_e_d;
		end
	end

	// Limit of the current timed phase; the timer saturates at all ones.
	always_comb begin
		case (phase_q)
			PH_UNLOCK:   timer_lim = cfg.unlock_drive;
			PH_RELEASE:  timer_lim = cfg.release_t;
			PH_DEBOUNCE: timer_lim = cfg.debounce;
			PH_SETTLE:   timer_lim = cfg.settle;
			PH_LOCK:     timer_lim = cfg.lock_drive;
			default:     timer_lim = '0;
		endcase
	end

	assign timer_inc = (timer_q != '1) ? timer_q + 1'b1 : timer_q;
	assign timer_end = (timer_inc >= timer_lim);

	// Bits below the select bit are checked against key E; after it, the
	// key that the select bit chose is used.
	assign count_inc = count_q + 1'b1;
	assign bit_idx   = count_q[IDX_W-1:0];
	assign bit_val   = (kind_s1 == KIND_BIT1);
	always_comb begin
		if (count_q > COUNT_W'(SELECT_BIT) && !use_e_q) begin
			want_bit = cfg.key_c[bit_idx];
		end else begin
			want_bit = cfg.key_e[bit_idx];
		end
	end
	assign mis_new = mis_q | ((count_q != COUNT_W'(SELECT_BIT)) & (want_bit != bit_val));

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		count_d = count_q;
		mis_d   = mis_q;
		use_e_d = use_e_q;
		acc_d   = 1'b0;
		rej_d   = 1'b0;
		if (advance) begin
			case (kind_s1)
				KIND_TICK: begin
					case (phase_q)
						PH_UNLOCK: begin
							timer_d = timer_end ? '0 : timer_inc;
							if (timer_end) phase_d = PH_RELEASE;
						end
						PH_RELEASE: begin
							timer_d = timer_end ? '0 : timer_inc;
							if (timer_end) phase_d = PH_WATCH;
						end
						PH_WATCH: begin
							if (door_s1) begin
								phase_d = PH_DEBOUNCE;
								timer_d = '0;
							end
						end
						PH_DEBOUNCE: begin
							timer_d = timer_end ? '0 : timer_inc;
							// The sample on the last debounce tick decides.
							if (timer_end) phase_d = door_s1 ? PH_SETTLE : PH_WATCH;
						end
						PH_SETTLE: begin
							timer_d = timer_end ? '0 : timer_inc;
							if (timer_end) phase_d = PH_LOCK;
						end
						PH_LOCK: begin
							timer_d = timer_end ? '0 : timer_inc;
							if (timer_end) begin
								phase_d = PH_IDLE;
								count_d = '0;
							end
						end
						default: begin
							phase_d = PH_IDLE;
							timer_d = '0;
						end
					endcase
				end
				KIND_BIT0, KIND_BIT1: begin
					// Card bits count only while idle and the code is not full.
					if (phase_q == PH_IDLE && count_q < COUNT_W'(CODE_BITS)) begin
						if (count_q == COUNT_W'(SELECT_BIT)) begin
							use_e_d = bit_val;
						end
						mis_d   = mis_new;
						count_d = count_inc;
						if (count_inc == COUNT_W'(CODE_BITS)) begin
							if (!mis_new) begin
								acc_d   = 1'b1;
								phase_d = PH_UNLOCK;
								timer_d = '0;
							end else begin
								rej_d   = 1'b1;
								mis_d   = 1'b0;
								count_d = '0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result register, loaded from the state after the update.
	// ------------------------------------------------------------------
	servo_t servo_d;
	logic   busy_d;

	always_comb begin
		case (phase_d)
			PH_UNLOCK: servo_d = SERVO_UNLOCK;
			PH_LOCK:   servo_d = SERVO_LOCK;
			default:   servo_d = SERVO_OFF;
		endcase
	end
	assign busy_d = (phase_d != PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (~m_tvalid | m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= M_TDATA_W'({count_d, acc_d, rej_d, busy_d, servo_d});
		end
	end

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CODE_BITS))
		else $error("bit count ran past the code length");

	a_accept_starts_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		acc_d |=> phase_q == PH_UNLOCK)
		else $error("accepted code did not start the unlock drive");

	a_reject_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rej_d |=> count_q == '0 && !mis_q && phase_q == PH_IDLE)
		else $error("rejected code did not clear the receiver");

	a_single_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
		else $error("code both accepted and rejected");

	a_busy_ignores_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q != PH_IDLE && kind_s1 != KIND_TICK) |=> $stable(count_q))
		else $error("card bit counted during the door sequence");

endmodule

// File: hdl/wkdc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiegand key door controller register file
// Holds the two keys and the five phase times written over the config port.
// ----------------------------------------------------------------------------
module wkdc_regs
	import wkdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic wr_en;

	// Writes are always taken; cfg_ready is tied high.
	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.key_e        <= '0;
			cfg.key_c        <= '0;
			cfg.unlock_drive <= UNLOCK_DRIVE_RST;
			cfg.release_t    <= RELEASE_RST;
			cfg.debounce     <= DEBOUNCE_RST;
			cfg.settle       <= SETTLE_RST;
			cfg.lock_drive   <= LOCK_DRIVE_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_KEY_E:        cfg.key_e        <= cfg_data[CODE_BITS-1:0];
				REG_KEY_C:        cfg.key_c        <= cfg_data[CODE_BITS-1:0];
				REG_UNLOCK_DRIVE: cfg.unlock_drive <= cfg_data[TIME_W-1:0];
				REG_RELEASE:      cfg.release_t    <= cfg_data[TIME_W-1:0];
				REG_DEBOUNCE:     cfg.debounce     <= cfg_data[TIME_W-1:0];
				REG_SETTLE:       cfg.settle       <= cfg_data[TIME_W-1:0];
				REG_LOCK_DRIVE:   cfg.lock_drive   <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wiegand key door controller testbench
// Drives card bit pulses and millisecond ticks into the controller. A local
// model of the key checker and door sequencer predicts every result item,
// and a checker compares each one field by field.
// ----------------------------------------------------------------------------
module testbench;
	import wkdc_pkg::*;

	// Input kind and register index that have no meaning in the block. They
	// must still be harmless.
	localparam logic [1:0]           KIND_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = CFG_IDX_W'(NUM_REGS);

	// Cycles in a row with no handshake on any port before the run is called
	// hung. The longest correct quiet spell is the forced receiver hold.
	localparam int STALL_LIMIT  = 2000;
	localparam int SINK_HOLD    = 200;
	// The block holds at most a couple of items in flight.
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES  = 16;
	localparam int RANDOM_ITEMS = 950;

	// Door samples for the directed tick walk, oldest first. With every
	// timer at zero this passes a failed debounce and then a good one.
	localparam logic [8:0] DOOR_PATTERN = 9'b0_0110_1000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;   // [0] door_low, rest zero
	logic [S_TUSER_W-1:0]  s_tuser = '0;   // [1:0] kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [1:0] servo_cmd, [2] door_busy, [3] key_rejected, [4] key_accepted,
	// [9:5] bits_received, rest zero
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	wiegand_key_door_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// One result item as the controller should report it.
	typedef struct {
		servo_t               servo;
		logic                 busy;
		logic                 rejected;
		logic                 accepted;
		logic [COUNT_W-1:0]   nbits;
	} door_result_t;

	door_result_t door_expected[$];

	int fail_count = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	// Idle controls. The sender and the receiver each draw random gaps
	// unless their quiet flag is set; sink_hold_cycles asks the receiver
	// for one long hold-off.
	bit gapless = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_gap = 0;
	int sink_hold_cycles = 0;

	// Copy of the register file, loaded with the reset values.
	logic [CODE_BITS-1:0] set_key_e    = '0;
	logic [CODE_BITS-1:0] set_key_c    = '0;
	logic [TIME_W-1:0]    set_unlock   = UNLOCK_DRIVE_RST;
	logic [TIME_W-1:0]    set_release  = RELEASE_RST;
	logic [TIME_W-1:0]    set_debounce = DEBOUNCE_RST;
	logic [TIME_W-1:0]    set_settle   = SETTLE_RST;
	logic [TIME_W-1:0]    set_lock     = LOCK_DRIVE_RST;

	// Receiver and sequencer state as the model sees it.
	logic [COUNT_W-1:0] card_count   = '0;
	logic               card_bad     = 1'b0;
	logic               upper_from_e = 1'b0;
	phase_t             door_phase   = PH_IDLE;
	logic [TIME_W-1:0]  door_timer   = '0;

	// One tick of a timed phase. The timer saturates, and the phase is over
	// on the tick where it reaches the limit, so a limit of zero ends the
	// phase on its first tick.
	function automatic bit timer_expired(logic [TIME_W-1:0] limit);
		if (door_timer != '1)
			door_timer++;
		if (door_timer >= limit) begin
			door_timer = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advances the model by one input item and returns the result item.
	function automatic door_result_t door_step(logic [1:0] kind, logic door_low);
		door_result_t r;
		logic         card_bit;
		r.accepted = 1'b0;
		r.rejected = 1'b0;
		if (kind == KIND_TICK) begin
			case (door_phase)
				PH_UNLOCK: begin
					if (timer_expired(set_unlock))
						door_phase = PH_RELEASE;
				end
				PH_RELEASE: begin
					if (timer_expired(set_release))
						door_phase = PH_WATCH;
				end
				PH_WATCH: begin
					if (door_low) begin
						door_phase = PH_DEBOUNCE;
						door_timer = '0;
					end
				end
				PH_DEBOUNCE: begin
					// The sample on the closing tick of the debounce decides.
					if (timer_expired(set_debounce))
						door_phase = door_low ? PH_SETTLE : PH_WATCH;
				end
				PH_SETTLE: begin
					if (timer_expired(set_settle))
						door_phase = PH_LOCK;
				end
				PH_LOCK: begin
					if (timer_expired(set_lock)) begin
						door_phase = PH_IDLE;
						card_count = '0;
					end
				end
				default: begin
					door_phase = PH_IDLE;
					door_timer = '0;
				end
			endcase
		end else if ((kind == KIND_BIT0 || kind == KIND_BIT1) &&
				door_phase == PH_IDLE && card_count < CODE_BITS) begin
			// Card bits only count while idle and below the code length.
			card_bit = (kind == KIND_BIT1);
			if (card_count < SELECT_BIT) begin
				if (set_key_e[card_count] != card_bit)
					card_bad = 1'b1;
			end else if (card_count == SELECT_BIT) begin
				upper_from_e = card_bit;
			end else if ((upper_from_e ? set_key_e[card_count] : set_key_c[card_count])
					!= card_bit) begin
				card_bad = 1'b1;
			end
			card_count++;
			if (card_count == CODE_BITS) begin
				if (!card_bad) begin
					r.accepted = 1'b1;
					door_phase = PH_UNLOCK;
					door_timer = '0;
				end else begin
					r.rejected = 1'b1;
					card_bad   = 1'b0;
					card_count = '0;
				end
			end
		end
		r.servo = (door_phase == PH_UNLOCK) ? SERVO_UNLOCK :
			(door_phase == PH_LOCK) ? SERVO_LOCK : SERVO_OFF;
		r.busy  = (door_phase != PH_IDLE);
		r.nbits = card_count;
		return r;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_key();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return CFG_DATA_W'($urandom);
	endfunction

	// Short time in the low bits, junk above them that the block must drop.
	function automatic logic [CFG_DATA_W-1:0] random_time();
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'($urandom);
		v[TIME_W-1:0] = TIME_W'($urandom_range(0, 4));
		return v;
	endfunction

	// A card code that matches the current keys for the given select bit.
	function automatic logic [CODE_BITS-1:0] card_for_keys(logic sel);
		logic [CODE_BITS-1:0] c;
		c = sel ? set_key_e : set_key_c;
		c[SELECT_BIT-1:0] = set_key_e[SELECT_BIT-1:0];
		c[SELECT_BIT] = sel;
		return c;
	endfunction

	// Offers one item after a random gap and records its expected result once
	// the block has taken it. Valid stays high between back-to-back items.
	task automatic send_item(logic [1:0] kind, logic door_low);
		int gap;
		gap = pick_gap(gapless);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_TDATA_W-1){1'b0}}, door_low};
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		door_expected.push_back(door_step(kind, door_low));
		items_sent++;
	endtask

	// Writes one register. The caller lowers cfg_valid after its last write,
	// so that back-to-back writes keep valid high.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_KEY_E:        set_key_e    = data;
			REG_KEY_C:        set_key_c    = data;
			REG_UNLOCK_DRIVE: set_unlock   = data[TIME_W-1:0];
			REG_RELEASE:      set_release  = data[TIME_W-1:0];
			REG_DEBOUNCE:     set_debounce = data[TIME_W-1:0];
			REG_SETTLE:       set_settle   = data[TIME_W-1:0];
			REG_LOCK_DRIVE:   set_lock     = data[TIME_W-1:0];
			default: ;
		endcase
	endtask

	// Sends a card code bit by bit, lowest bit first. The door line is
	// random since the block ignores it on card bits.
	task automatic send_card(logic [CODE_BITS-1:0] code, int nbits);
		for (int i = 0; i < nbits; i++)
			send_item(code[i] ? KIND_BIT1 : KIND_BIT0, 1'($urandom_range(0, 1)));
	endtask

	// Completes any partial card with zero bits, then ticks the door
	// sequence back to idle. Stray card bits are mixed in while it runs.
	task automatic finish_card_and_door(int pct_closed);
		while (card_count != 0 || door_phase != PH_IDLE) begin
			if (door_phase == PH_IDLE)
				send_item(KIND_BIT0, 1'b0);
			else if ($urandom_range(0, 9) == 0)
				send_item($urandom_range(0, 1) ? KIND_BIT1 : KIND_BIT0, 1'b1);
			else
				send_item(KIND_TICK, $urandom_range(0, 99) < pct_closed);
		end
	endtask

	// Stops offering items and waits for every result to come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (door_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
		fail_count++;
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// Reset values: both keys zero and the long default timings. The first
	// item is the unused kind, which must leave everything untouched. The
	// unlock drive runs for a while on its default time, then shorter times
	// are written between items so the sequence ends soon.
	task automatic test_reset_defaults();
		send_item(KIND_SPARE, 1'b1);
		send_card(card_for_keys(1'($urandom_range(0, 1))), CODE_BITS);
		repeat (20) send_item(KIND_TICK, 1'b1);
		drain_results();
		write_reg(REG_UNLOCK_DRIVE, CFG_DATA_W'(25));
		write_reg(REG_RELEASE, CFG_DATA_W'(3));
		write_reg(REG_DEBOUNCE, CFG_DATA_W'(2));
		write_reg(REG_SETTLE, CFG_DATA_W'(4));
		write_reg(REG_LOCK_DRIVE, CFG_DATA_W'(5));
		cfg_valid <= 1'b0;
		finish_card_and_door(80);
		drain_results();
	endtask

	// Directed cards against all-ones and all-zero keys with every timer at
	// zero, then a walk through the door sequence tick by tick.
	task automatic test_card_cases();
		logic [CODE_BITS-1:0] card;
		write_reg(REG_KEY_E, '1);
		write_reg(REG_KEY_C, '0);
		write_reg(REG_UNLOCK_DRIVE, {10'h3ff, 16'h0000});
		write_reg(REG_RELEASE, {10'h2aa, 16'h0000});
		write_reg(REG_DEBOUNCE, {10'h155, 16'h0000});
		write_reg(REG_SETTLE, {10'h3ff, 16'h0000});
		write_reg(REG_LOCK_DRIVE, {10'h001, 16'h0000});
		cfg_valid <= 1'b0;

		// Unused kind and ticks while idle, door line both ways.
		send_item(KIND_SPARE, 1'b0);
		send_item(KIND_TICK, 1'b0);
		send_item(KIND_TICK, 1'b1);

		// Only the last bit is wrong: the code is rejected on that bit.
		card = card_for_keys(1'b1);
		card[CODE_BITS-1] = ~card[CODE_BITS-1];
		send_card(card, CODE_BITS);

		// A wrong first bit is remembered until the code is complete.
		card = card_for_keys(1'b0);
		card[0] = ~card[0];
		send_card(card, CODE_BITS);

		// Select bit low: the upper bits are checked against the second key.
		send_card(card_for_keys(1'b0), CODE_BITS);
		// A card bit during the sequence is ignored.
		send_item(KIND_BIT1, 1'b0);
		for (int i = 0; i < 9; i++)
			send_item(KIND_TICK, DOOR_PATTERN[i]);
		finish_card_and_door(50);
		drain_results();
	endtask

	// A longer unlock time, written with every upper data bit set so that the
	// block must keep only the low sixteen. Sent without gaps to keep it short.
	task automatic test_long_unlock_timer();
		write_reg(REG_UNLOCK_DRIVE, {10'h3ff, 16'd40});
		write_reg(REG_RELEASE, {10'h155, 16'h0000});
		write_reg(REG_DEBOUNCE, CFG_DATA_W'(1));
		write_reg(REG_SETTLE, CFG_DATA_W'(2));
		write_reg(REG_LOCK_DRIVE, CFG_DATA_W'(3));
		cfg_valid <= 1'b0;
		gapless  = 1'b1;
		rx_quiet = 1'b1;
		send_card(card_for_keys(1'b1), CODE_BITS);
		finish_card_and_door(90);
		gapless  = 1'b0;
		rx_quiet = 1'b0;
		drain_results();
	endtask

	// The receiver holds off for a long stretch while items keep coming, so
	// the block fills and stops taking input. The sender then pauses until
	// every result is in.
	task automatic test_stall_recovery();
		write_reg(REG_UNLOCK_DRIVE, CFG_DATA_W'(2));
		cfg_valid <= 1'b0;
		sink_hold_cycles = SINK_HOLD;
		gapless = 1'b1;
		send_card(card_for_keys(1'b0), CODE_BITS);
		repeat (20) send_item(KIND_TICK, 1'b1);
		gapless = 1'b0;
		drain_results();
		finish_card_and_door(80);
		drain_results();
	endtask

	// Mostly matching cards with random content and short timers, some
	// corrupted cards and some raw noise. Settings change every few rounds.
	task automatic test_random_traffic();
		int                   first;
		int                   round;
		int                   pick;
		logic [CODE_BITS-1:0] card;
		first = items_sent;
		round = 0;
		while (items_sent - first < RANDOM_ITEMS) begin
			if (round % 6 == 0) begin
				drain_results();
				write_reg(REG_KEY_E, random_key());
				write_reg(REG_KEY_C, random_key());
				write_reg(REG_UNLOCK_DRIVE, random_time());
				write_reg(REG_RELEASE, random_time());
				write_reg(REG_DEBOUNCE, random_time());
				write_reg(REG_SETTLE, random_time());
				write_reg(REG_LOCK_DRIVE, random_time());
				if ($urandom_range(0, 1))
					write_reg(REG_SPARE, CFG_DATA_W'($urandom));
				cfg_valid <= 1'b0;
			end
			// Every few rounds both sides run flat out.
			gapless  = (round % 7 == 5);
			rx_quiet = gapless;
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_card(card_for_keys(1'($urandom_range(0, 1))), CODE_BITS);
			end else if (pick < 85) begin
				card = card_for_keys(1'($urandom_range(0, 1)));
				card[$urandom_range(0, CODE_BITS - 1)] ^= 1'b1;
				send_card(card, CODE_BITS);
			end else begin
				repeat ($urandom_range(4, 12))
					send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			end
			finish_card_and_door($urandom_range(40, 95));
			round++;
		end
		gapless  = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Result sink. A requested hold is counted out here; otherwise ready
	// drops for random gaps unless the quiet flag is set.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (sink_hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold_cycles) @(posedge clk);
				sink_hold_cycles = 0;
				m_tready <= 1'b1;
			end else if (rx_quiet || rx_gap == 0) begin
				m_tready <= 1'b1;
				if (!rx_quiet && $urandom_range(0, 3) == 0)
					rx_gap = pick_gap(1'b0);
			end else begin
				m_tready <= 1'b0;
				rx_gap--;
			end
		end
	end

	// Every accepted result is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		door_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (door_expected.size() == 0) begin
				fail_count++;
				$display("%0t ns: result item %h arrived with nothing expected",
					$time, m_tdata);
			end else begin
				want = door_expected.pop_front();
				if (m_tdata[1:0] !== want.servo)
					report_mismatch("servo_cmd", 16'(want.servo), 16'(m_tdata[1:0]));
				if (m_tdata[2] !== want.busy)
					report_mismatch("door_busy", 16'(want.busy), 16'(m_tdata[2]));
				if (m_tdata[3] !== want.rejected)
					report_mismatch("key_rejected", 16'(want.rejected), 16'(m_tdata[3]));
				if (m_tdata[4] !== want.accepted)
					report_mismatch("key_accepted", 16'(want.accepted), 16'(m_tdata[4]));
				if (m_tdata[5 +: COUNT_W] !== want.nbits)
					report_mismatch("bits_received", 16'(want.nbits),
						16'(m_tdata[5 +: COUNT_W]));
				if (m_tdata[M_TDATA_W-1:OUT_W] !== '0)
					report_mismatch("tdata padding", '0,
						16'(m_tdata[M_TDATA_W-1:OUT_W]));
			end
		end
	end

	// Hang detector: any handshake on any port restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_card_cases();
		test_long_unlock_timer();
		test_stall_recovery();
		test_random_traffic();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
